@@ design/iir_filter_direct_form_unit_macros.svh @@
// Assertion helpers for the filter RTL.
`ifndef IIR_FILTER_DIRECT_FORM_UNIT_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IIRDF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, disabled during reset.
`define IIRDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ design/iirdf_pkg.sv @@
package iirdf_pkg;
	localparam int TAPS = 50;
	localparam int SW = 32;
	localparam int CW = 32;
	localparam int COEF_FRAC = CW - 4;
	localparam int ACC_W = 72;
	localparam int CNT_W = $clog2(TAPS);
	localparam int DCNT_W = $clog2(ACC_W);

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_NUM = 2'd1;
	localparam logic [1:0] CMD_DEN = 2'd2;

	localparam logic CFG_CLAMP_LOW = 1'b0;
	localparam logic CFG_CLAMP_HIGH = 1'b1;

	localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [ACC_W-1:0] Q_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic [ACC_W-1:0] Q_MIN_MAG = {{(ACC_W-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
	localparam logic signed [CW-1:0] COEF_ONE = {{(CW-COEF_FRAC-1){1'b0}}, 1'b1,
		{COEF_FRAC{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] a;
	} cell_data_t;

	typedef struct packed {
		logic shift_x;
		logic shift_y;
		logic rotate;
	} cell_ctrl_t;
endpackage

@@ design/iirdf_cell.sv @@
module iirdf_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iirdf_pkg::cell_ctrl_t      ctrl,
	input  logic                       wr_b,
	input  logic                       wr_a,
	input  logic signed [iirdf_pkg::CW-1:0] wr_data,
	input  iirdf_pkg::cell_data_t      prev,
	input  iirdf_pkg::cell_data_t      nxt,
	output iirdf_pkg::cell_data_t      dat
);
	iirdf_pkg::cell_data_t dat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dat_q <= '0;
		end else if (ctrl.rotate) begin
			// advance the ring one place toward the MAC end
			dat_q <= nxt;
		end else begin
			if (ctrl.shift_x) dat_q.x <= prev.x;
			if (ctrl.shift_y) dat_q.y <= prev.y;
			if (wr_b) dat_q.b <= wr_data;
			if (wr_a) dat_q.a <= wr_data;
		end
	end

	assign dat = dat_q;
endmodule

@@ design/iir_filter_direct_form_unit.sv @@
// Sequence from an accepted sample request to y_out valid: TAPS ring rotations
// through one pair of multipliers, a drain and a setup state, a 72-step
// restoring divide, then the finish states. One sample in flight at a time:
// a new request waits until the result is loaded into y_out, longer while y_out is held.
// Coefficient requests give no result.
// Reset (arst_n low, asynchronous) clears histories, coefficients and clamps;
// the leading denominator coefficient resets to 1.0.
module iir_filter_direct_form_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic [5:0]              coef_index,
	input  logic signed [31:0]      value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      y_out
);
	localparam int TAPS = iirdf_pkg::TAPS;
	localparam int SW = iirdf_pkg::SW;
	localparam int CW = iirdf_pkg::CW;
	localparam int ACC_W = iirdf_pkg::ACC_W;

	iirdf_pkg::state_t state_q, state_d;
	logic [iirdf_pkg::CNT_W-1:0] cnt_q;
	logic [iirdf_pkg::DCNT_W-1:0] div_cnt_q;
	logic signed [SW-1:0] clamp_low_q, clamp_high_q;
	logic signed [CW-1:0] a0_q;
	logic signed [2*SW-1:0] px_s1, py_s1;
	logic mul_v_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] nq_q;
	logic [CW-1:0] rem_q, dmag_q;
	logic neg_q, dzero_q;
	logic signed [SW-1:0] y_res_q;
	logic out_valid_q;
	logic signed [SW-1:0] y_out_q;

	logic accept, take_sample, out_free, mac_last;
	iirdf_pkg::cell_ctrl_t ctrl;
	iirdf_pkg::cell_data_t dat [TAPS];
	iirdf_pkg::cell_data_t head;

	assign accept = in_valid && in_ready;
	assign take_sample = accept && (cmd == iirdf_pkg::CMD_SAMPLE);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == iirdf_pkg::ST_IDLE);
	assign mac_last = (state_q == iirdf_pkg::ST_MAC) &&
		(cnt_q == iirdf_pkg::CNT_W'(TAPS - 1));

	assign ctrl.shift_x = take_sample;
	assign ctrl.shift_y = (state_q == iirdf_pkg::ST_DONE) && out_free;
	assign ctrl.rotate = (state_q == iirdf_pkg::ST_MAC);

	assign head.x = value;
	assign head.y = y_res_q;
	assign head.b = '0;
	assign head.a = '0;

	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_cell
			logic wr_b, wr_a;
			assign wr_b = accept && (cmd == iirdf_pkg::CMD_NUM) && (coef_index == 6'(k));
			assign wr_a = accept && (cmd == iirdf_pkg::CMD_DEN) && (coef_index == 6'(k + 1));
			iirdf_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.wr_b(wr_b),
				.wr_a(wr_a),
				.wr_data(value),
				.prev((k == 0) ? head : dat[(k == 0) ? 0 : k - 1]),
				.nxt(dat[(k + 1) % TAPS]),
				.dat(dat[k])
			);
		end
	endgenerate

	// divide step: bring down one dividend bit
	logic [CW:0] rshift;
	logic div_ge;
	logic [CW-1:0] rem_nxt;
	always_comb begin
		rshift = {rem_q, nq_q[ACC_W-1]};
		div_ge = (rshift >= {1'b0, dmag_q});
		rem_nxt = div_ge ? CW'(rshift - {1'b0, dmag_q}) : rshift[CW-1:0];
	end

	// saturate the quotient to the sample range
	logic signed [SW-1:0] y_sat;
	always_comb begin
		if (dzero_q) begin
			if (acc_q == '0) y_sat = '0;
			else if (acc_q[ACC_W-1]) y_sat = iirdf_pkg::Y_MIN;
			else y_sat = iirdf_pkg::Y_MAX;
		end else if (neg_q) begin
			if (nq_q > iirdf_pkg::Q_MIN_MAG) y_sat = iirdf_pkg::Y_MIN;
			else y_sat = SW'(-nq_q[SW-1:0]);
		end else begin
			if (nq_q > iirdf_pkg::Q_MAX) y_sat = iirdf_pkg::Y_MAX;
			else y_sat = nq_q[SW-1:0];
		end
	end

	logic signed [SW-1:0] y_clamped;
	always_comb begin
		y_clamped = y_res_q;
		if (!(clamp_low_q == '0 && clamp_high_q == '0)) begin
			if (y_res_q > clamp_high_q) y_clamped = clamp_high_q;
			else if (y_res_q < clamp_low_q) y_clamped = clamp_low_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iirdf_pkg::ST_IDLE: if (take_sample) state_d = iirdf_pkg::ST_MAC;
			iirdf_pkg::ST_MAC: if (cnt_q == iirdf_pkg::CNT_W'(TAPS - 1))
				state_d = iirdf_pkg::ST_DRAIN;
			iirdf_pkg::ST_DRAIN: state_d = iirdf_pkg::ST_PREP;
			iirdf_pkg::ST_PREP: state_d = iirdf_pkg::ST_DIV;
			iirdf_pkg::ST_DIV: if (div_cnt_q == iirdf_pkg::DCNT_W'(ACC_W - 1))
				state_d = iirdf_pkg::ST_FIN;
			iirdf_pkg::ST_FIN: state_d = iirdf_pkg::ST_DONE;
			iirdf_pkg::ST_DONE: if (out_free) state_d = iirdf_pkg::ST_IDLE;
			default: state_d = iirdf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			div_cnt_q <= '0;
			clamp_low_q <= '0;
			clamp_high_q <= '0;
			a0_q <= iirdf_pkg::COEF_ONE;
			mul_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == iirdf_pkg::CFG_CLAMP_LOW) clamp_low_q <= cfg_data;
				else clamp_high_q <= cfg_data;
			end
			if (accept && cmd == iirdf_pkg::CMD_DEN && coef_index == 6'd0) a0_q <= value;
			mul_v_s1 <= (state_q == iirdf_pkg::ST_MAC);
			if (take_sample) cnt_q <= '0;
			else if (state_q == iirdf_pkg::ST_MAC) cnt_q <= cnt_q + 1'b1;
			if (state_q == iirdf_pkg::ST_PREP) div_cnt_q <= '0;
			else if (state_q == iirdf_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
			if (state_q == iirdf_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= dat[0].x * dat[0].b;
		py_s1 <= dat[0].y * dat[0].a;
		if (take_sample) acc_q <= '0;
		else if (mul_v_s1)
			acc_q <= acc_q + ACC_W'(px_s1) - ACC_W'(py_s1);
		if (state_q == iirdf_pkg::ST_PREP) begin
			nq_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
			rem_q <= '0;
			dmag_q <= a0_q[CW-1] ? CW'(-a0_q) : a0_q;
			neg_q <= acc_q[ACC_W-1] ^ a0_q[CW-1];
			dzero_q <= (a0_q == '0);
		end else if (state_q == iirdf_pkg::ST_DIV) begin
			nq_q <= {nq_q[ACC_W-2:0], div_ge};
			rem_q <= rem_nxt;
		end
		if (state_q == iirdf_pkg::ST_FIN) y_res_q <= y_sat;
		if (state_q == iirdf_pkg::ST_DONE && out_free) y_out_q <= y_clamped;
	end

	assign out_valid = out_valid_q;
	assign y_out = y_out_q;

	`include "iir_filter_direct_form_unit_macros.svh"

	`IIRDF_ASSERT_NEXT(a_sample_starts, take_sample, state_q == iirdf_pkg::ST_MAC)
	`IIRDF_ASSERT_NEXT(a_mac_ends, mac_last, state_q == iirdf_pkg::ST_DRAIN)
	`IIRDF_ASSERT_NOW(a_div_bound, state_q == iirdf_pkg::ST_DIV, div_cnt_q < iirdf_pkg::DCNT_W'(ACC_W))
endmodule

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int TAPS = iirdf_pkg::TAPS;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 160;
	localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = iirdf_pkg::CFG_CLAMP_LOW;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = iirdf_pkg::CMD_SAMPLE;
	logic [5:0] coef_index = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] y_out;

	iir_filter_direct_form_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.coef_index(coef_index), .value(value), .out_valid(out_valid),
		.out_ready(out_ready), .y_out(y_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// filter model state
	logic signed [31:0] x_hist [TAPS];
	logic signed [31:0] y_hist [TAPS];
	logic signed [31:0] num_coef [TAPS];
	logic signed [31:0] den_coef [TAPS+1];
	logic signed [31:0] clamp_lo = '0;
	logic signed [31:0] clamp_hi = '0;
	logic signed [31:0] y_expected [$];

	int errors = 0;
	int n_requests = 0;
	int n_samples = 0;
	int n_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic logic signed [31:0] sat_sample(input logic signed [127:0] q);
		if (q > 128'sd2147483647) return iirdf_pkg::Y_MAX;
		if (q < -128'sd2147483648) return iirdf_pkg::Y_MIN;
		return q[31:0];
	endfunction

	task automatic filter_step(input logic [1:0] c, input logic [5:0] ix,
			input logic signed [31:0] v);
		logic signed [127:0] acc;
		logic signed [31:0] y;
		acc = '0;
		if (c == iirdf_pkg::CMD_NUM) begin
			if (ix < TAPS) num_coef[ix] = v;
		end else if (c == iirdf_pkg::CMD_DEN) begin
			if (ix <= TAPS) den_coef[ix] = v;
		end else if (c == iirdf_pkg::CMD_SAMPLE) begin
			for (int k = TAPS - 1; k >= 1; k--) x_hist[k] = x_hist[k-1];
			x_hist[0] = v;
			for (int k = 0; k < TAPS; k++) begin
				acc += 128'(x_hist[k]) * 128'(num_coef[k]);
				acc -= 128'(y_hist[k]) * 128'(den_coef[k+1]);
			end
			if (den_coef[0] == 0)
				y = (acc == 0) ? '0 : (acc < 0 ? iirdf_pkg::Y_MIN : iirdf_pkg::Y_MAX);
			else
				y = sat_sample(acc / 128'(den_coef[0]));
			for (int k = TAPS - 1; k >= 1; k--) y_hist[k] = y_hist[k-1];
			y_hist[0] = y;
			if (!(clamp_lo == 0 && clamp_hi == 0)) begin
				if (y > clamp_hi) y = clamp_hi;
				else if (y < clamp_lo) y = clamp_lo;
			end
			y_expected.push_back(y);
			n_samples++;
		end
	endtask

	task automatic send_req(input logic [1:0] c, input logic [5:0] ix,
			input logic signed [31:0] v);
		// idle the sender in a share of cycles before the request
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		coef_index <= ix;
		value <= v;
		do @(posedge clk); while (!in_ready);
		filter_step(c, ix, v);
		n_requests++;
	endtask

	// drop valid and wait until every result is in and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (y_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_clamps(input logic signed [31:0] lo, input logic signed [31:0] hi);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= iirdf_pkg::CFG_CLAMP_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= iirdf_pkg::CFG_CLAMP_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		clamp_lo = lo;
		clamp_hi = hi;
	endtask

	// result checker and receiver-side stalls
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (y_expected.size() == 0) begin
				$display("%0t: unexpected y_out %0d", $realtime, y_out);
				errors++;
			end else begin
				if (y_out !== y_expected[0]) begin
					$display("%0t: y_out mismatch expected %0d actual %0d",
						$realtime, y_expected[0], y_out);
					errors++;
				end
				void'(y_expected.pop_front());
				n_checked++;
			end
		end
		if (hold_off_req) begin
			hold_off_req = 0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic signed [31:0] small_coef(input int shift);
		return $signed($urandom_range(0, 2 << shift)) - (1 << shift);
	endfunction

	function automatic logic signed [31:0] rand_sample();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
	endfunction

	task automatic test_directed();
		// all coefficients zero: output stays zero; then b0 = 1.0 and the output follows the input
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sh7fff_ffff);
		send_req(iirdf_pkg::CMD_NUM, 6'd0, ONE_Q28);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sh7fff_ffff);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sh8000_0000);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, -32'sd1);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sd0);
		// out-of-range indexes and unused command change nothing; then the last numerator tap is set
		send_req(iirdf_pkg::CMD_NUM, 6'd50, 32'sh7fff_ffff);
		send_req(iirdf_pkg::CMD_DEN, 6'd51, 32'sh8000_0000);
		send_req(iirdf_pkg::CMD_NUM, 6'd63, 32'sh8000_0000);
		send_req(CMD_UNUSED, 6'd0, 32'sh7fff_ffff);
		send_req(iirdf_pkg::CMD_NUM, 6'd49, 32'sh7fff_ffff);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, ONE_Q16);
		// zero leading coefficient: result goes to the extremes by sign
		send_req(iirdf_pkg::CMD_DEN, 6'd0, 32'sd0);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, ONE_Q16);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, -ONE_Q16);
		send_req(iirdf_pkg::CMD_NUM, 6'd49, 32'sd0);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sd0);
		// divide by 2.0, negative divisor, feedback through last pole
		send_req(iirdf_pkg::CMD_DEN, 6'd0, ONE_Q28 <<< 1);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sd3);
		send_req(iirdf_pkg::CMD_DEN, 6'd0, -ONE_Q28);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, -32'sd7);
		send_req(iirdf_pkg::CMD_DEN, 6'd0, ONE_Q28);
		send_req(iirdf_pkg::CMD_DEN, 6'd50, 32'sh8000_0000);
		send_req(iirdf_pkg::CMD_DEN, 6'd1, ONE_Q28 >>> 1);
		send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, 32'sh0123_4567);
	endtask

	task automatic test_clamps();
		set_clamps(-ONE_Q16, ONE_Q16);
		repeat (6) send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, rand_sample());
		set_clamps(32'sh8000_0000, 32'sh7fff_ffff);
		repeat (4) send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, rand_sample());
		// inverted limits: the upper one is checked first, values above it take it, the rest the lower one
		set_clamps(ONE_Q16, -ONE_Q16);
		repeat (4) send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, rand_sample());
		set_clamps(32'sd0, 32'sd0);
	endtask

	task automatic random_mix(input int n_items);
		int pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, rand_sample());
			else if (pick < 82)
				send_req(iirdf_pkg::CMD_NUM, 6'($urandom_range(0, TAPS - 1)),
					small_coef(26));
			else if (pick < 90)
				send_req(iirdf_pkg::CMD_DEN, 6'($urandom_range(1, TAPS)), small_coef(21));
			else if (pick < 93)
				send_req(iirdf_pkg::CMD_DEN, 6'd0, ($urandom_range(0, 7) == 0) ? $urandom() :
					ONE_Q28 + small_coef(27));
			else if (pick < 96)
				send_req(2'($urandom_range(iirdf_pkg::CMD_NUM, iirdf_pkg::CMD_DEN)),
					6'($urandom_range(0, 63)), $urandom());
			else if (pick < 98)
				send_req(CMD_UNUSED, 6'($urandom_range(0, 63)), $urandom());
			else
				send_req(iirdf_pkg::CMD_NUM, 6'($urandom_range(0, TAPS - 1)), $urandom());
		end
	endtask

	task automatic test_random();
		send_idle_pct = 18;
		recv_idle_pct = 69;
		random_mix(450);
		set_clamps($signed($urandom_range(0, 1 << 24)) - (1 << 24),
			$urandom_range(0, 1 << 24));
		send_idle_pct = 69;
		recv_idle_pct = 18;
		random_mix(450);
		set_clamps(32'sh8000_0000, 32'sh7fff_ffff);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_mix(450);
	endtask

	// hold the receiver while requests keep coming so the input stalls
	task automatic test_backpressure();
		drain();
		hold_off_req = 1;
		repeat (8) send_req(iirdf_pkg::CMD_SAMPLE, 6'd0, rand_sample());
	endtask

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			x_hist[k] = '0;
			y_hist[k] = '0;
			num_coef[k] = '0;
			den_coef[k] = '0;
		end
		den_coef[TAPS] = '0;
		den_coef[0] = ONE_Q28;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clamps();
		test_backpressure();
		test_random();
		drain();
		$display("Covered %0d requests, %0d filter samples, %0d outputs checked,",
			n_requests, n_samples, n_checked);
		$display("with clamp settings, coefficient edge cases and stalls on both sides.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire
